FILE: rtl/rfds_pkg.sv
// Shared constants and types for the ring FIFO with drop statistics.
`default_nettype none

package rfds_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MODE_BITS         = 3;
   localparam int OFFSET_BITS       = 4;
   localparam int STATUS_BITS       = 3;
   localparam int CTR_BITS          = 32;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_WRITE       = 3'd0,
      MODE_READ        = 3'd1,
      MODE_PEEK_HEAD   = 3'd2,
      MODE_PEEK_OFFSET = 3'd3,
      MODE_CLEAR       = 3'd4,
      MODE_CLEAR_ALL   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 3'd0,
      ST_DROPPED    = 3'd1,
      ST_WRITE_HELD = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_READ_HELD  = 3'd4,
      ST_BEYOND     = 3'd5
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_SEEK
   } fsm_type;

endpackage

`default_nettype wire

FILE: rtl/ring_fifo_with_drop_stats_top.sv
// Top level: transaction control, pointers, counters and result register around the ring.
// Ops without a store access retire as soon as the response register is free; store
//   accesses also wait in the SEEK state for their address to rotate into cell 0.
// One transaction at a time: a new request is taken only after the last one has retired,
//   and retiring waits while a pending response is held by rsp_ready low.
// Reset (synchronous, active high): empty store, counters zero, blocking mode on.
// Store words are not cleared by reset; only written entries are ever read.
`default_nettype none

module ring_fifo_with_drop_stats_top import rfds_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [WORD_BITS-1:0]   req_write_data,
   input  logic [OFFSET_BITS-1:0] req_entry_offset,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_BITS-1:0]   rsp_read_data,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [CNT_BITS-1:0]    rsp_fill_level,
   output logic                   rsp_is_full,
   output logic                   rsp_is_empty,
   output logic [CTR_BITS-1:0]    rsp_writes_done,
   output logic [CTR_BITS-1:0]    rsp_reads_done,
   output logic [CTR_BITS-1:0]    rsp_writes_dropped
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int SUM_BITS = ((PTR_BITS > OFFSET_BITS) ? PTR_BITS : OFFSET_BITS) + 1;
   localparam int CMP_BITS = (CNT_BITS > OFFSET_BITS) ? CNT_BITS : OFFSET_BITS;

   // control state
   fsm_type              state_ff, state_in;
   logic                 blocking_ff;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CTR_BITS-1:0]  wr_ctr_ff, wr_ctr_in;
   logic [CTR_BITS-1:0]  rd_ctr_ff, rd_ctr_in;
   logic [CTR_BITS-1:0]  drop_ctr_ff, drop_ctr_in;
   logic                 rsp_valid_ff;

   // latched transaction
   mode_type               cmd_mode_ff;
   logic [WORD_BITS-1:0]   cmd_data_ff;
   logic [OFFSET_BITS-1:0] cmd_offset_ff;

   // response payload
   logic [WORD_BITS-1:0]   rsp_data_ff;
   status_type             rsp_status_ff;
   logic [CNT_BITS-1:0]    rsp_fill_ff;
   logic [CTR_BITS-1:0]    rsp_wr_ff, rsp_rd_ff, rsp_drop_ff;

   // ring interface
   logic                 load_en;
   logic [WORD_BITS-1:0] head_word;
   logic [PTR_BITS-1:0]  slot, slot_next;

   // decode
   logic                 accept;
   logic                 out_free;
   logic                 finish;
   logic                 need_access;
   logic                 access_hit;
   logic                 is_full_now;
   logic                 is_empty_now;
   logic                 beyond_fill;
   logic [SUM_BITS-1:0]  offset_sum;
   logic [PTR_BITS-1:0]  offset_addr;
   status_type           status_c;
   logic [WORD_BITS-1:0] rdata_c;

   function automatic logic [PTR_BITS-1:0] ptr_advance(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   rfds_ring #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .load_data (cmd_data_ff),
      .head_word (head_word),
      .slot      (slot),
      .slot_next (slot_next)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // head + offset wraps at most once when the peek is in range
   always_comb begin
      offset_sum  = SUM_BITS'(head_ff) + SUM_BITS'(cmd_offset_ff);
      offset_addr = (offset_sum >= SUM_BITS'(DEPTH)) ?
                    PTR_BITS'(offset_sum - SUM_BITS'(DEPTH)) : PTR_BITS'(offset_sum);
      is_full_now  = (count_ff == CNT_BITS'(DEPTH));
      is_empty_now = (count_ff == '0);
      beyond_fill  = (CMP_BITS'(cmd_offset_ff) >= CMP_BITS'(count_ff));
   end

   // Decide what the latched transaction needs. A store write lands in cell 0
   // as its address rotates in; reads sample cell 0 while it holds the address.
   always_comb begin
      status_c    = ST_OK;
      need_access = 1'b0;
      access_hit  = 1'b0;
      unique case (cmd_mode_ff)
         MODE_WRITE: begin
            if (is_full_now) begin
               status_c = blocking_ff ? ST_WRITE_HELD : ST_DROPPED;
            end else begin
               need_access = 1'b1;
               access_hit  = (slot_next == tail_ff);
            end
         end
         MODE_READ: begin
            if (is_empty_now) begin
               status_c = blocking_ff ? ST_READ_HELD : ST_EMPTY;
            end else begin
               need_access = 1'b1;
               access_hit  = (slot == head_ff);
            end
         end
         MODE_PEEK_HEAD: begin
            if (is_empty_now) begin
               status_c = ST_EMPTY;
            end else begin
               need_access = 1'b1;
               access_hit  = (slot == head_ff);
            end
         end
         MODE_PEEK_OFFSET: begin
            if (beyond_fill) begin
               status_c = ST_BEYOND;
            end else begin
               need_access = 1'b1;
               access_hit  = (slot == offset_addr);
            end
         end
         default: begin
         end
      endcase
      rdata_c = (need_access && cmd_mode_ff != MODE_WRITE) ? head_word : '0;
   end

   // Sequencer: one transaction in flight; it retires once any store access it needs
   // is aligned with cell 0 and the response register can take the result.
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      wr_ctr_in   = wr_ctr_ff;
      rd_ctr_in   = rd_ctr_ff;
      drop_ctr_in = drop_ctr_ff;
      finish      = 1'b0;
      load_en     = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = FSM_SEEK;
            end
         end
         FSM_SEEK: begin
            finish = out_free && (!need_access || access_hit);
            if (finish) begin
               state_in = FSM_IDLE;
               unique case (cmd_mode_ff)
                  MODE_WRITE: begin
                     if (need_access) begin
                        load_en   = 1'b1;
                        tail_in   = ptr_advance(tail_ff);
                        count_in  = count_ff + 1'b1;
                        wr_ctr_in = wr_ctr_ff + 1'b1;
                     end else if (!blocking_ff) begin
                        drop_ctr_in = drop_ctr_ff + 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (need_access) begin
                        head_in   = ptr_advance(head_ff);
                        count_in  = count_ff - 1'b1;
                        rd_ctr_in = rd_ctr_ff + 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  MODE_CLEAR_ALL: begin
                     head_in     = '0;
                     tail_in     = '0;
                     count_in    = '0;
                     wr_ctr_in   = '0;
                     rd_ctr_in   = '0;
                     drop_ctr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         blocking_ff  <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         wr_ctr_ff    <= '0;
         rd_ctr_ff    <= '0;
         drop_ctr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         wr_ctr_ff   <= wr_ctr_in;
         rd_ctr_ff   <= rd_ctr_in;
         drop_ctr_ff <= drop_ctr_in;
         if (csr_write_enable) begin
            blocking_ff <= csr_write_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_mode_ff   <= mode_type'(req_mode);
         cmd_data_ff   <= req_write_data;
         cmd_offset_ff <= req_entry_offset;
      end
      if (finish) begin
         rsp_data_ff   <= rdata_c;
         rsp_status_ff <= status_c;
         rsp_fill_ff   <= count_in;
         rsp_wr_ff     <= wr_ctr_in;
         rsp_rd_ff     <= rd_ctr_in;
         rsp_drop_ff   <= drop_ctr_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_fill_level     = rsp_fill_ff;
   assign rsp_is_full        = (rsp_fill_ff == CNT_BITS'(DEPTH));
   assign rsp_is_empty       = (rsp_fill_ff == '0);
   assign rsp_writes_done    = rsp_wr_ff;
   assign rsp_reads_done     = rsp_rd_ff;
   assign rsp_writes_dropped = rsp_drop_ff;

endmodule

`default_nettype wire

FILE: rtl/rfds_cell.sv
// One storage cell of the rotating word ring.
`default_nettype none

module rfds_cell import rfds_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic [WORD_BITS-1:0] shift_in,
   input  logic                 load_en,
   input  logic [WORD_BITS-1:0] load_data,
   output logic [WORD_BITS-1:0] word_out
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   // take the neighbor's word, or a new word on a store write
   always_comb begin
      word_in = load_en ? load_data : shift_in;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

FILE: rtl/rfds_ring.sv
// Ring of cells rotating one place per cycle, with the slot tracker for cell 0.
`default_nettype none

module rfds_ring import rfds_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   localparam int PTR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_en,
   input  logic [WORD_BITS-1:0] load_data,
   output logic [WORD_BITS-1:0] head_word,
   output logic [PTR_BITS-1:0]  slot,
   output logic [PTR_BITS-1:0]  slot_next
);

   logic [WORD_BITS-1:0] chain [DEPTH];
   logic                 cell_load [DEPTH];
   logic [PTR_BITS-1:0]  slot_ff;
   logic [PTR_BITS-1:0]  slot_in;

   // cell k holds address slot_ff - k; cell 0 refills from the last cell
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam int PREV = (k == 0) ? DEPTH - 1 : k - 1;

      assign cell_load[k] = (k == 0) ? load_en : 1'b0;

      rfds_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .shift_in  (chain[PREV]),
         .load_en   (cell_load[k]),
         .load_data (load_data),
         .word_out  (chain[k])
      );
   end

   always_comb begin
      slot_in = (slot_ff == PTR_BITS'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign head_word = chain[0];
   assign slot      = slot_ff;
   assign slot_next = slot_in;

endmodule

`default_nettype wire

FILE: rtl/rfds_checker.sv
// Port-level assertions for the ring FIFO top level, with its bind.
`default_nettype none

module rfds_checker import rfds_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic [WORD_BITS-1:0]   rsp_read_data,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [CNT_BITS-1:0]    rsp_fill_level,
   input logic                   rsp_is_full,
   input logic                   rsp_is_empty
);

   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another transaction is in flight");

   a_flags_match_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_is_empty == (rsp_fill_level == '0)) &&
                     (rsp_is_full == (rsp_fill_level == CNT_BITS'(DEPTH)))))
      else $error("full/empty flags disagree with fill level");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_level <= CNT_BITS'(DEPTH)))
      else $error("fill level beyond depth");

   a_refused_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == '0))
      else $error("refused access returned nonzero data");

endmodule

bind ring_fifo_with_drop_stats_top rfds_checker #(
   .DEPTH     (DEPTH),
   .WORD_BITS (WORD_BITS)
) u_rfds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_read_data  (rsp_read_data),
   .rsp_status     (rsp_status),
   .rsp_fill_level (rsp_fill_level),
   .rsp_is_full    (rsp_is_full),
   .rsp_is_empty   (rsp_is_empty)
);

`default_nettype wire
